@@ src/bdhr_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce and HID report package
// Shared widths, item layouts, register indexes and LED levels.
// ----------------------------------------------------------------------------
`default_nettype none

package bdhr_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned RawBits    = 3;
  localparam int unsigned Slots      = 3;
  localparam int unsigned ButtonIdxW = 2;

  localparam logic [15:0] DebounceReset  = 16'd25;
  localparam logic [15:0] PairHoldReset  = 16'd5000;
  localparam logic [15:0] BlinkHalfReset = 16'd900;
  localparam logic [1:0]  PairBtnReset   = 2'd1;
  localparam logic [7:0]  KeyTopReset    = 8'h3E;
  localparam logic [7:0]  KeyMidReset    = 8'h3F;
  localparam logic [7:0]  KeyBotReset    = 8'h40;

  localparam logic [7:0] RedLevel   = 8'd60;
  localparam logic [7:0] GreenLevel = 8'd25;
  localparam logic [7:0] BlueLevel  = 8'd40;

  typedef enum logic [2:0] {
    RegDebounceMs  = 3'd0,
    RegPairHoldMs  = 3'd1,
    RegBlinkHalfMs = 3'd2,
    RegPairButton  = 3'd3,
    RegKeyCodeTop  = 3'd4,
    RegKeyCodeMid  = 3'd5,
    RegKeyCodeBot  = 3'd6
  } cfg_reg_e;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic        link_up;
    logic [2:0]  raw_down;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [4:0] pad;
    logic       led_update;
    logic [7:0] led_blue;
    logic [7:0] led_green;
    logic [7:0] led_red;
    logic       pairing_request;
    logic [7:0] key_slot_c;
    logic [7:0] key_slot_b;
    logic [7:0] key_slot_a;
    logic       send_report;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/button_debounce_hid_report_unit.sv @@
// ----------------------------------------------------------------------------
// Button debounce and HID report unit
// Lockout debounce, keyboard report packing, pairing hold and LED color.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the slave stream is one sample tick: a millisecond
// timestamp, three raw button levels and the link-up flag. Every tick yields
// exactly one transfer on the master stream carrying the report flag, three
// key slots, the pairing pulse, the LED color and the LED update flag.
// A tick is first captured in an input register; the debounce, pairing and
// LED logic then runs combinationally on the way into the output register.
// The unit sustains one tick per cycle while m_axis_tready_i is high, so
// throughput is set only by the receiver.
// When the receiver stalls, the output register holds its result and the
// input register holds one more tick, after which s_axis_tready_o drops.
// Reset clears all buttons to released, all stamps to zero, the blink phase
// to off and marks the LED as never written, and loads the configuration
// registers with their default values. Configuration writes are always
// accepted and should only be made while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hid_report_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Sample ticks.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata from bit 0: now_ms[31:0], raw_down[34:32], link_up[35], zero pad.
  input  wire logic [39:0] s_axis_tdata_i,
  // Results.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata from bit 0: send_report[0], key_slot_a[8:1], key_slot_b[16:9],
  // key_slot_c[24:17], pairing_request[25], led_red[33:26],
  // led_green[41:34], led_blue[49:42], led_update[50], zero pad.
  output logic [55:0]      m_axis_tdata_o
);

  localparam int unsigned NB = bdhr_pkg::NumButtons;

  // Configuration registers.
  logic [15:0] debounce_q, pair_hold_q, blink_half_q;
  logic [1:0]  pair_btn_q;
  logic [7:0]  key_top_q, key_mid_q, key_bot_q;

  // Tick state.
  logic [NB-1:0] pressed_q, pressed_d;
  logic [31:0]   stamp_q [NB];
  logic [31:0]   stamp_d [NB];
  logic          fired_q, fired_d;
  logic          phase_q, phase_d;
  logic [31:0]   blink_stamp_q, blink_stamp_d;
  logic [23:0]   last_color_q, last_color_d;
  logic          written_q;

  // Pipeline registers.
  logic                in_valid_q;
  bdhr_pkg::in_item_t  in_q;
  logic                out_valid_q;
  bdhr_pkg::out_item_t out_q, out_d;
  logic                advance;

  // The input register moves forward whenever the output register is free
  // or is being emptied in this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign cfg_ready_o     = 1'b1;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdhr_pkg::DebounceReset;
      pair_hold_q  <= bdhr_pkg::PairHoldReset;
      blink_half_q <= bdhr_pkg::BlinkHalfReset;
      pair_btn_q   <= bdhr_pkg::PairBtnReset;
      key_top_q    <= bdhr_pkg::KeyTopReset;
      key_mid_q    <= bdhr_pkg::KeyMidReset;
      key_bot_q    <= bdhr_pkg::KeyBotReset;
    end else if (cfg_valid_i) begin
      case (bdhr_pkg::cfg_reg_e'(cfg_index_i))
        bdhr_pkg::RegDebounceMs:  debounce_q   <= cfg_data_i;
        bdhr_pkg::RegPairHoldMs:  pair_hold_q  <= cfg_data_i;
        bdhr_pkg::RegBlinkHalfMs: blink_half_q <= cfg_data_i;
        bdhr_pkg::RegPairButton:  pair_btn_q   <= cfg_data_i[1:0];
        bdhr_pkg::RegKeyCodeTop:  key_top_q    <= cfg_data_i[7:0];
        bdhr_pkg::RegKeyCodeMid:  key_mid_q    <= cfg_data_i[7:0];
        bdhr_pkg::RegKeyCodeBot:  key_bot_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Per-button helpers. Buttons beyond the raw level bits stay released and
  // carry key code zero.
  logic [NB+bdhr_pkg::RawBits-1:0] raw_ext;
  logic [7:0]    code [NB];
  logic [NB-1:0] change;
  logic          changed;
  logic          send;
  logic [7:0]    slot [bdhr_pkg::Slots];
  logic [1:0]    fill;
  logic          pair_valid;
  logic          pair_down;
  logic [31:0]   pair_stamp;
  logic          pulse;
  logic          any_down;
  logic [7:0]    red, green, blue;
  logic [31:0]   blink_elapsed;

  assign raw_ext = (NB + bdhr_pkg::RawBits)'(in_q.raw_down);

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      case (i)
        0:       code[i] = key_top_q;
        1:       code[i] = key_mid_q;
        2:       code[i] = key_bot_q;
        default: code[i] = 8'd0;
      endcase
    end
  end

  // Lockout debounce: a level change is taken only once the debounce time
  // has passed since that button's last accepted change (modulo 2^32).
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      change[i]    = (raw_ext[i] != pressed_q[i]) &&
                     ((in_q.now_ms - stamp_q[i]) >= {16'd0, debounce_q});
      pressed_d[i] = change[i] ? raw_ext[i] : pressed_q[i];
      stamp_d[i]   = change[i] ? in_q.now_ms : stamp_q[i];
    end
    changed  = |change;
    any_down = |pressed_d;
    send     = changed && in_q.link_up;
  end

  // Report packing: when a report is sent, pressed keys fill the slots in button order.
  always_comb begin
    for (int s = 0; s < bdhr_pkg::Slots; s++) begin
      slot[s] = 8'd0;
    end
    fill = 2'd0;
    if (send) begin
      for (int i = 0; i < NB; i++) begin
        if (pressed_d[i] && (fill < 2'(bdhr_pkg::Slots))) begin
          slot[fill] = code[i];
          fill       = fill + 2'd1;
        end
      end
    end
  end

  // Pairing hold: one pulse per press of the selected button once it has
  // been held for the hold time. An out-of-range selection disarms it.
  always_comb begin
    pair_valid = 1'b0;
    pair_down  = 1'b0;
    pair_stamp = 32'd0;
    for (int i = 0; i < NB; i++) begin
      if (pair_btn_q == bdhr_pkg::ButtonIdxW'(i)) begin
        pair_valid = 1'b1;
        pair_down  = pressed_d[i];
        pair_stamp = stamp_d[i];
      end
    end
    pulse   = 1'b0;
    fired_d = fired_q;
    if (!pair_valid) begin
      fired_d = 1'b0;
    end else if (pair_down && !fired_q &&
                 ((in_q.now_ms - pair_stamp) >= {16'd0, pair_hold_q})) begin
      fired_d = 1'b1;
      pulse   = 1'b1;
    end else if (!pair_down) begin
      fired_d = 1'b0;
    end
  end

  // LED color by priority. The blink timer runs only while no button is down and the link is down.
  assign blink_elapsed = in_q.now_ms - blink_stamp_q;

  always_comb begin
    red           = 8'd0;
    green         = 8'd0;
    blue          = 8'd0;
    phase_d       = phase_q;
    blink_stamp_d = blink_stamp_q;
    if (any_down) begin
      red = bdhr_pkg::RedLevel;
    end else if (in_q.link_up) begin
      blue = bdhr_pkg::BlueLevel;
    end else begin
      if (blink_elapsed >= {16'd0, blink_half_q}) begin
        blink_stamp_d = in_q.now_ms;
        phase_d       = !phase_q;
      end
      if (phase_d) begin
        green = bdhr_pkg::GreenLevel;
      end
    end
    last_color_d = {red, green, blue};
  end

  always_comb begin
    out_d                 = '0;
    out_d.send_report     = send;
    out_d.key_slot_a      = slot[0];
    out_d.key_slot_b      = slot[1];
    out_d.key_slot_c      = slot[2];
    out_d.pairing_request = pulse;
    out_d.led_red         = red;
    out_d.led_green       = green;
    out_d.led_blue        = blue;
    out_d.led_update      = !written_q || (last_color_d != last_color_q);
  end

  // Control and tick state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      pressed_q     <= '0;
      for (int i = 0; i < NB; i++) begin
        stamp_q[i] <= 32'd0;
      end
      fired_q       <= 1'b0;
      phase_q       <= 1'b0;
      blink_stamp_q <= 32'd0;
      last_color_q  <= 24'd0;
      written_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        pressed_q     <= pressed_d;
        for (int i = 0; i < NB; i++) begin
          stamp_q[i] <= stamp_d[i];
        end
        fired_q       <= fired_d;
        phase_q       <= phase_d;
        blink_stamp_q <= blink_stamp_d;
        last_color_q  <= last_color_d;
        written_q     <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= bdhr_pkg::in_item_t'(s_axis_tdata_i);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // A pairing pulse needs its button pressed, so the LED must show red.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pairing_request |-> out_q.led_red == bdhr_pkg::RedLevel)
    else $error("pairing pulse without red LED");

  // The LED shows at most one color channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones({out_q.led_red != 8'd0, out_q.led_green != 8'd0,
                                out_q.led_blue != 8'd0}) <= 1)
    else $error("more than one LED channel lit");

  // A held tick that cannot move on is still held in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input tick dropped");

  // Key slots are empty whenever no report is sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.send_report |->
      (out_q.key_slot_a == 8'd0) && (out_q.key_slot_b == 8'd0) &&
      (out_q.key_slot_c == 8'd0))
    else $error("key slots set without report");

endmodule

`default_nettype wire
